// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the triangle metrics RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an antecedent implies a consequent, same cycle or later.
`define TRM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds.
`define TRM_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: hw/rtl/trm_pkg.sv
// Package for the triangle metrics block: payload words, state codes,
// controller-datapath command and status structs. No dependencies.
`default_nettype none

package trm_pkg;

    localparam logic [6:0] PERIOD_CAP_RST = 7'd25;
    localparam int         DIV_STEPS      = 64;
    localparam int         SQRT_STEPS     = 32;
    localparam int         MUL_STEPS      = 8;

    typedef struct packed {
        logic        [19:0] tri_id;
        logic        [15:0] version;
        logic signed [23:0] ax;
        logic signed [23:0] ay;
        logic signed [23:0] bx;
        logic signed [23:0] by;
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic        [31:0] val_a;
        logic        [31:0] val_b;
        logic        [31:0] val_c;
    } tri_in_t;

    typedef struct packed {
        logic [19:0] out_id;
        logic [15:0] out_version;
        logic [49:0] tri_area;
        logic [31:0] value_span;
        logic [31:0] edge_ratio;
        logic        is_interesting;
    } tri_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_SORT,
        ST_RUN,
        ST_DONE
    } trm_state_t;

    typedef struct packed {
        logic load;
        logic diff;
        logic mul;
        logic sort;
        logic run;
        logic push;
    } trm_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic run_done;
    } trm_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/trm_ctrl.sv
// Sequencer for the triangle metrics block: state machine and output valid.
// Depends on trm_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module trm_ctrl import trm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    input  wire trm_stat_t stat,
    output trm_cmd_t       cmd
);

    trm_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    // Result slot can take a word when empty or being drained
    assign out_free = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_DIFF;
            ST_DIFF: state_next = ST_MUL;
            ST_MUL:  if (stat.mul_done) state_next = ST_SORT;
            ST_SORT: state_next = ST_RUN;
            ST_RUN:  if (stat.run_done) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands and handshake outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_DIFF: cmd.diff = 1'b1;
            ST_MUL:  cmd.mul  = 1'b1;
            ST_SORT: cmd.sort = 1'b1;
            ST_RUN:  cmd.run  = 1'b1;
            ST_DONE: cmd.push = out_free;
            default: cmd      = '0;
        endcase
        out_valid_next = cmd.push ? 1'b1 : (out_valid_reg && out_stall);
    end

    assign out_valid = out_valid_reg;

    // State and result-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `TRM_ASSERT(a_accept_starts, (in_valid && !in_stall) |=> (state_reg == ST_DIFF), "accepted word did not start work")
    `TRM_ASSERT(a_valid_from_done, $rose(out_valid) |-> ($past(state_reg) == ST_DONE), "result shown without finishing")
    `TRM_ASSERT(a_run_holds, (state_reg == ST_RUN && !stat.run_done) |=> (state_reg == ST_RUN), "left run before units finished")

endmodule

`default_nettype wire

// File: hw/rtl/trm_datapath.sv
// Datapath for the triangle metrics block: shared multiplier, divider,
// square root, fraction scan, config register and result register. Uses trm_pkg.
`default_nettype none

module trm_datapath import trm_pkg::*;
#(
    parameter int PERIOD_LIMIT = 64
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_we,
    input  wire logic [6:0] cfg_data,
    input  wire tri_in_t  in_data,
    input  wire trm_cmd_t cmd,
    output trm_stat_t     stat,
    output tri_out_t      out_data
);

    localparam int PW = $clog2(PERIOD_LIMIT + 1);
    localparam int CW = (PW > 7) ? PW : 7;
    localparam int MW = 32 + PW;

    // Config register
    logic [6:0] mp_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) mp_reg <= PERIOD_CAP_RST;
        else if (cfg_we) mp_reg <= cfg_data;
    end

    logic [PW-1:0] p_eff;
    assign p_eff = (CW'(mp_reg) > CW'(PERIOD_LIMIT)) ? PW'(PERIOD_LIMIT) : PW'(mp_reg);

    // Input word and edge vectors
    tri_in_t            in_reg;
    logic signed [24:0] e1x_reg, e1y_reg, e2x_reg, e2y_reg, fx_reg, fy_reg;
    logic        [31:0] vmin_reg, vmax_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load) in_reg <= in_data;
        if (cmd.diff)
        begin
            e1x_reg  <= $signed({in_reg.bx[23], in_reg.bx}) - $signed({in_reg.ax[23], in_reg.ax});
            e1y_reg  <= $signed({in_reg.by[23], in_reg.by}) - $signed({in_reg.ay[23], in_reg.ay});
            e2x_reg  <= $signed({in_reg.cx[23], in_reg.cx}) - $signed({in_reg.ax[23], in_reg.ax});
            e2y_reg  <= $signed({in_reg.cy[23], in_reg.cy}) - $signed({in_reg.ay[23], in_reg.ay});
            fx_reg   <= $signed({in_reg.cx[23], in_reg.cx}) - $signed({in_reg.bx[23], in_reg.bx});
            fy_reg   <= $signed({in_reg.cy[23], in_reg.cy}) - $signed({in_reg.by[23], in_reg.by});
            vmin_reg <= (in_reg.val_a < in_reg.val_b) ?
                        ((in_reg.val_a < in_reg.val_c) ? in_reg.val_a : in_reg.val_c) :
                        ((in_reg.val_b < in_reg.val_c) ? in_reg.val_b : in_reg.val_c);
            vmax_reg <= (in_reg.val_a > in_reg.val_b) ?
                        ((in_reg.val_a > in_reg.val_c) ? in_reg.val_a : in_reg.val_c) :
                        ((in_reg.val_b > in_reg.val_c) ? in_reg.val_b : in_reg.val_c);
        end
    end

    // Shared multiplier: cross product terms, then squared edge lengths
    logic        [3:0]  mcnt_reg;
    logic        [2:0]  pidx_reg;
    logic               pvld_reg;
    logic signed [49:0] prod_reg;
    logic signed [24:0] opa, opb;
    logic signed [49:0] mul_p;
    logic signed [50:0] det_reg;
    logic        [49:0] l0_reg, l1_reg, l2_reg;

    always_comb
    begin
        case (mcnt_reg[2:0])
            3'd0:    begin opa = e1x_reg; opb = e2y_reg; end
            3'd1:    begin opa = e1y_reg; opb = e2x_reg; end
            3'd2:    begin opa = e1x_reg; opb = e1x_reg; end
            3'd3:    begin opa = e1y_reg; opb = e1y_reg; end
            3'd4:    begin opa = fx_reg;  opb = fx_reg;  end
            3'd5:    begin opa = fy_reg;  opb = fy_reg;  end
            3'd6:    begin opa = e2x_reg; opb = e2x_reg; end
            default: begin opa = e2y_reg; opb = e2y_reg; end
        endcase
    end

    assign mul_p         = opa * opb;
    assign stat.mul_done = (mcnt_reg == 4'(MUL_STEPS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcnt_reg <= '0;
            pvld_reg <= 1'b0;
        end
        else if (cmd.diff)
        begin
            mcnt_reg <= '0;
            pvld_reg <= 1'b0;
        end
        else if (cmd.mul)
        begin
            pvld_reg <= !stat.mul_done;
            if (!stat.mul_done) mcnt_reg <= mcnt_reg + 4'd1;
        end
    end

    // Accumulate each product in the cycle after the multiplier forms it
    always_ff @(posedge clk)
    begin
        if (cmd.mul && !stat.mul_done)
        begin
            prod_reg <= mul_p;
            pidx_reg <= mcnt_reg[2:0];
        end
        if (cmd.mul && pvld_reg)
        begin
            case (pidx_reg)
                3'd0:    det_reg <= {prod_reg[49], prod_reg};
                3'd1:    det_reg <= det_reg - {prod_reg[49], prod_reg};
                3'd2:    l0_reg  <= prod_reg;
                3'd3:    l0_reg  <= l0_reg + prod_reg;
                3'd4:    l1_reg  <= prod_reg;
                3'd5:    l1_reg  <= l1_reg + prod_reg;
                3'd6:    l2_reg  <= prod_reg;
                default: l2_reg  <= l2_reg + prod_reg;
            endcase
        end
    end

    // Sort edges, finish area and span, arm the units
    logic [49:0] lmax_c, lmin_c, lmin_reg;
    logic [50:0] adet;
    logic [49:0] area_reg;
    logic [31:0] span_reg;

    always_comb
    begin
        lmax_c = l0_reg;
        lmin_c = l0_reg;
        if (l1_reg > lmax_c) lmax_c = l1_reg;
        if (l2_reg > lmax_c) lmax_c = l2_reg;
        if (l1_reg < lmin_c) lmin_c = l1_reg;
        if (l2_reg < lmin_c) lmin_c = l2_reg;
        adet = det_reg[50] ? 51'(-det_reg) : 51'(det_reg);
    end

    // Ratio unit: divide lmax*2^32 by lmin, then take the square root
    logic        sat_reg;
    logic [6:0]  step_reg;
    logic [49:0] rem_reg;
    logic [63:0] dvd_reg, quo_reg;
    logic [31:0] root_reg;
    logic [50:0] trial;
    logic [50:0] trial_sub;
    logic [31:0] cand;
    logic [63:0] csq;
    logic        ratio_done;

    assign trial      = {rem_reg, dvd_reg[63]};
    assign trial_sub  = trial - {1'b0, lmin_reg};
    assign cand       = root_reg | (32'd1 << (~step_reg[4:0]));
    assign csq        = 64'(cand) * 64'(cand);
    assign ratio_done = sat_reg || (step_reg == 7'(DIV_STEPS + SQRT_STEPS));

    // Fraction scan: one denominator per cycle
    logic [PW-1:0]   d_reg;
    logic            hit_reg, scan_done_reg;
    logic [MW-1:0]   lo_d, hi_d;
    logic [MW:0]     lo_up;
    logic [MW-16:0]  n_raw, n_sel;
    logic            scan_hit;

    assign lo_d     = MW'(vmin_reg) * MW'(d_reg);
    assign hi_d     = MW'(vmax_reg) * MW'(d_reg);
    assign lo_up    = (MW+1)'(lo_d) + (MW+1)'(16'hFFFF);
    assign n_raw    = lo_up[MW:16];
    assign n_sel    = (n_raw < (MW-15)'(d_reg)) ? (MW-15)'(d_reg) : n_raw;
    assign scan_hit = (n_sel <= (MW-15)'(p_eff)) &&
                      ({n_sel, 16'b0} <= (MW+1)'(hi_d));

    assign stat.run_done = ratio_done && scan_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg       <= 1'b1;
            step_reg      <= '0;
            scan_done_reg <= 1'b1;
            hit_reg       <= 1'b0;
            d_reg         <= '0;
        end
        else if (cmd.sort)
        begin
            sat_reg       <= (lmin_c == '0) || ({32'b0, lmax_c[49:32]} >= lmin_c);
            step_reg      <= '0;
            d_reg         <= PW'(1);
            hit_reg       <= 1'b0;
            scan_done_reg <= (p_eff == '0);
        end
        else if (cmd.run)
        begin
            if (!ratio_done) step_reg <= step_reg + 7'd1;
            if (!scan_done_reg)
            begin
                if (scan_hit)
                begin
                    hit_reg       <= 1'b1;
                    scan_done_reg <= 1'b1;
                end
                else if (d_reg == p_eff)
                    scan_done_reg <= 1'b1;
                else
                    d_reg <= d_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sort)
        begin
            lmin_reg <= lmin_c;
            rem_reg  <= {32'b0, lmax_c[49:32]};
            dvd_reg  <= {lmax_c[31:0], 32'b0};
            quo_reg  <= '0;
            root_reg <= '0;
            area_reg <= adet[50:1];
            span_reg <= vmax_reg - vmin_reg;
        end
        else if (cmd.run && !ratio_done)
        begin
            if (step_reg < 7'(DIV_STEPS))
            begin
                // restoring division step
                dvd_reg <= {dvd_reg[62:0], 1'b0};
                if (!trial_sub[50])
                begin
                    rem_reg <= trial_sub[49:0];
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[49:0];
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
            end
            else if (csq <= quo_reg)
                // keep this root bit
                root_reg <= cand;
        end
    end

    // Result register
    tri_out_t out_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_reg.out_id         <= in_reg.tri_id;
            out_reg.out_version    <= in_reg.version;
            out_reg.tri_area       <= area_reg;
            out_reg.value_span     <= span_reg;
            out_reg.edge_ratio     <= sat_reg ? 32'hFFFF_FFFF : root_reg;
            out_reg.is_interesting <= hit_reg;
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/triangle_refinement_metrics.sv
// Top level of the triangle metrics block: joins sequencer and datapath.
// Depends on trm_pkg, trm_ctrl and trm_datapath.
//
//   channel | handshake           | word
//   --------+---------------------+-------------------------------
//   in      | in_valid / in_stall | tri_in_t  (triangle, values)
//   out     | out_valid/out_stall | tri_out_t (area, span, ratio, flag)
//   cfg     | cfg_valid/cfg_ready | period cap, 7 bits
//
// One triangle runs on the shared multiplier, then through 64 divider steps and
// 32 square-root steps, with the fraction scan (one denominator a cycle) running
// alongside. When an edge is degenerate or the ratio saturates, the divider and
// square root are skipped and the scan alone decides when the triangle is done.
// A stalled result holds the sequencer in its last state; a finished word waits
// in the output register while the next triangle is taken. Reset sets the cap
// to 25.
`default_nettype none

module triangle_refinement_metrics import trm_pkg::*;
#(
    parameter int PERIOD_LIMIT = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire tri_in_t    in_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output tri_out_t        out_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [6:0] cfg_data
);

    trm_cmd_t  cmd;
    trm_stat_t stat;

    // Config writes are always taken
    assign cfg_ready = 1'b1;

    trm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    trm_datapath #(
        .PERIOD_LIMIT (PERIOD_LIMIT)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

// File: dv/tb_triangle_refinement_metrics.sv
// Self-checking testbench for triangle_refinement_metrics: a directed table, then random
// triangles under several period-cap settings, with random valid/stall gaps on both sides.
// Depends on trm_pkg and the RTL of the block only.
`default_nettype none

module tb_triangle_refinement_metrics;
    import trm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_P  = 64;
    localparam int DRAIN_CY = 150;
    localparam logic [31:0] RATIO_SAT = 32'hFFFF_FFFF;

    typedef struct {
        tri_in_t  word;
        bit       typed;
        tri_out_t want;
    } dir_row_t;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    tri_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    tri_out_t out_data;
    logic     cfg_valid;
    logic     cfg_ready;
    logic [6:0] cfg_data;

    tri_out_t   metrics_q[$];
    logic [6:0] period_shadow;
    int         errors;
    int         stall_left;
    bit         quiet;
    dir_row_t   dir_rows[$];

    triangle_refinement_metrics #(.PERIOD_LIMIT(LIMIT_P)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Square-root ratio: largest r with r*r*lmin <= lmax << 32
    function automatic logic [31:0] ratio_of(logic [63:0] lmax, logic [63:0] lmin);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] lhs;
        logic [127:0] rhs;
        r = 0;
        if (lmin == 0)
            return RATIO_SAT;
        rhs = {lmax, 32'b0};
        for (int b = 31; b >= 0; b--)
        begin
            c   = r | (64'd1 << b);
            lhs = 128'(c * c) * 128'(lmin);
            if (lhs <= rhs)
                r = c;
        end
        return r[31:0];
    endfunction

    // Exact per-denominator test for a fraction n/d inside [lo, hi]
    function automatic bit fraction_hit(longint unsigned lo, longint unsigned hi,
                                        logic [6:0] period);
        longint unsigned p;
        longint unsigned n;
        p = (period > LIMIT_P) ? LIMIT_P : period;
        for (longint unsigned d = 1; d <= p; d++)
        begin
            n = (lo * d + 65535) >> 16;
            if (n < d)
                n = d;
            if (n <= p && (n << 16) <= hi * d)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic longint unsigned sq_len(longint dx, longint dy);
        return longint'(dx * dx) + longint'(dy * dy);
    endfunction

    function automatic tri_out_t tri_metrics(tri_in_t t, logic [6:0] period);
        tri_out_t        o;
        longint          ax, ay, bx, by, cx, cy, det;
        longint unsigned adet, l0, l1, l2, lmax, lmin, vmin, vmax;
        ax = t.ax; ay = t.ay; bx = t.bx; by = t.by; cx = t.cx; cy = t.cy;
        det  = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
        adet = (det < 0) ? -det : det;
        l0 = sq_len(bx - ax, by - ay);
        l1 = sq_len(cx - bx, cy - by);
        l2 = sq_len(ax - cx, ay - cy);
        lmax = l0; lmin = l0;
        if (l1 > lmax) lmax = l1;
        if (l2 > lmax) lmax = l2;
        if (l1 < lmin) lmin = l1;
        if (l2 < lmin) lmin = l2;
        vmin = t.val_a; vmax = t.val_a;
        if (t.val_b < vmin) vmin = t.val_b;
        if (t.val_c < vmin) vmin = t.val_c;
        if (t.val_b > vmax) vmax = t.val_b;
        if (t.val_c > vmax) vmax = t.val_c;
        o.out_id         = t.tri_id;
        o.out_version    = t.version;
        o.tri_area       = 50'(adet >> 1);
        o.value_span     = 32'(vmax - vmin);
        o.edge_ratio     = ratio_of(lmax, lmin);
        o.is_interesting = fraction_hit(vmin, vmax, period);
        return o;
    endfunction

    function automatic tri_in_t mk_tri(logic [19:0] id, logic [15:0] ver,
                                       int ax, int ay, int bx, int by, int cx, int cy,
                                       logic [31:0] va, logic [31:0] vb, logic [31:0] vc);
        tri_in_t t;
        t.tri_id = id; t.version = ver;
        t.ax = ax[23:0]; t.ay = ay[23:0]; t.bx = bx[23:0];
        t.by = by[23:0]; t.cx = cx[23:0]; t.cy = cy[23:0];
        t.val_a = va; t.val_b = vb; t.val_c = vc;
        return t;
    endfunction

    function automatic logic [31:0] rand_value();
        int unsigned n;
        int unsigned d;
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(65535);
            2:
            begin
                // land near a reference fraction
                d = $urandom_range(1, 70);
                n = $urandom_range(d, 70);
                return 32'((n << 16) / d) + 32'($urandom_range(8)) - 32'd4;
            end
            default: return 32'($urandom_range(80)) << 16;
        endcase
    endfunction

    function automatic int rand_coord(int span);
        if (span >= 23)
            return int'($urandom());
        return int'($urandom_range(2 * (1 << span))) - (1 << span);
    endfunction

    function automatic tri_in_t rand_tri();
        tri_in_t t;
        int      span;
        int      xs[6];
        span = ($urandom_range(3) == 0) ? 23 : $urandom_range(2, 16);
        foreach (xs[i])
            xs[i] = rand_coord(span);
        t = mk_tri(20'($urandom()), 16'($urandom()),
                   xs[0], xs[1], xs[2], xs[3], xs[4], xs[5],
                   rand_value(), rand_value(), rand_value());
        // collapse an edge now and then
        case ($urandom_range(9))
            0: begin t.bx = t.ax; t.by = t.ay; end
            1: begin t.cx = t.bx; t.cy = t.by; end
            2: begin t.cx = t.ax + 24'($urandom_range(3)); t.cy = t.ay; end
            default: ;
        endcase
        if ($urandom_range(7) == 0)
        begin
            t.val_b = t.val_a;
            t.val_c = t.val_a;
        end
        return t;
    endfunction

    // Drive one word after a gap; hold valid across back-to-back words
    task automatic send_tri(tri_in_t t, bit typed, tri_out_t want);
        int gap;
        gap = quiet ? 0 : $urandom_range(13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        metrics_q.insert(metrics_q.size(), typed ? want : tri_metrics(t, period_shadow));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (metrics_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CY) @(posedge clk);
    endtask

    task automatic set_period(logic [6:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        period_shadow = v;
    endtask

    // Output side: stall for a drawn count, then check each accepted word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else if (out_valid && !out_stall)
        begin
            if (metrics_q.size() == 0)
            begin
                $error("unexpected word out_id=%h", out_data.out_id);
                errors++;
            end
            else
            begin
                tri_out_t w;
                w = metrics_q.pop_front();
                if (out_data.out_id !== w.out_id)
                begin
                    $error("out_id exp %h got %h", w.out_id, out_data.out_id); errors++;
                end
                if (out_data.out_version !== w.out_version)
                begin
                    $error("out_version exp %h got %h", w.out_version,
                           out_data.out_version); errors++;
                end
                if (out_data.tri_area !== w.tri_area)
                begin
                    $error("tri_area exp %h got %h", w.tri_area, out_data.tri_area);
                    errors++;
                end
                if (out_data.value_span !== w.value_span)
                begin
                    $error("value_span exp %h got %h", w.value_span, out_data.value_span);
                    errors++;
                end
                if (out_data.edge_ratio !== w.edge_ratio)
                begin
                    $error("edge_ratio exp %h got %h", w.edge_ratio, out_data.edge_ratio);
                    errors++;
                end
                if (out_data.is_interesting !== w.is_interesting)
                begin
                    $error("is_interesting exp %b got %b", w.is_interesting,
                           out_data.is_interesting); errors++;
                end
            end
            stall_left = quiet ? 0 : $urandom_range(13);
            out_stall <= (stall_left != 0);
        end
        else
        begin
            if (stall_left > 0)
                stall_left = stall_left - 1;
            out_stall <= (stall_left != 0);
        end
    end

    // Hard stop
    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        tri_out_t    w;
        logic [6:0]  periods[6];
        clk = 1'b0; rst_n = 1'b0;
        in_valid = 1'b0; in_data = '0;
        cfg_valid = 1'b0; cfg_data = '0;
        errors = 0; quiet = 1'b0;
        period_shadow = PERIOD_CAP_RST;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: typed rows use a point triangle
        w = '{out_id: 20'h1, out_version: 16'h0, tri_area: 50'd0, value_span: 32'd0,
              edge_ratio: RATIO_SAT, is_interesting: 1'b0};
        dir_rows.insert(dir_rows.size(), '{mk_tri(20'h1, 16'h0, 0, 0, 0, 0, 0, 0,
                                                  32'h0, 32'h0, 32'h0), 1'b1, w});
        w = '{out_id: 20'hFFFFF, out_version: 16'hFFFF, tri_area: 50'd0, value_span: 32'd0,
              edge_ratio: RATIO_SAT, is_interesting: 1'b0};
        dir_rows.insert(dir_rows.size(), '{mk_tri(20'hFFFFF, 16'hFFFF, 5, 5, 5, 5, 5, 5,
                                    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF), 1'b1, w});
        w = '{out_id: 20'h3, out_version: 16'h3, tri_area: 50'd0, value_span: 32'd0,
              edge_ratio: RATIO_SAT, is_interesting: 1'b1};
        dir_rows.insert(dir_rows.size(), '{mk_tri(20'h3, 16'h3, 0, 0, 0, 0, 0, 0,
                                    32'h10000, 32'h10000, 32'h10000), 1'b1, w});
        w = '{out_id: 20'h4, out_version: 16'h4, tri_area: 50'd0,
              value_span: 32'hFFFFFFFF, edge_ratio: RATIO_SAT, is_interesting: 1'b1};
        dir_rows.insert(dir_rows.size(), '{mk_tri(20'h4, 16'h4, -8388608, 8388607,
                                    -8388608, 8388607, -8388608, 8388607,
                                    32'h0, 32'hFFFFFFFF, 32'h7), 1'b1, w});
        w = '{out_id: 20'h5, out_version: 16'h5, tri_area: 50'd0, value_span: 32'hFFFF,
              edge_ratio: RATIO_SAT, is_interesting: 1'b0};
        dir_rows.insert(dir_rows.size(), '{mk_tri(20'h5, 16'h5, 0, 0, 0, 0, 0, 0,
                                    32'h0, 32'hFFFF, 32'h0), 1'b1, w});
        // Extreme area and lengths, degenerate edge, thin and collinear shapes
        dir_rows.insert(dir_rows.size(), '{mk_tri(20'd6, 16'd6, -8388608, -8388608,
                                    8388607, -8388608, -8388608, 8388607,
                                    32'd1, 32'd2, 32'd3), 1'b0, w});
        dir_rows.insert(dir_rows.size(), '{mk_tri(20'd7, 16'd7, 8388607, 8388607,
                                    -8388608, -8388608, 8388607, -8388608,
                                    32'h190000, 32'h0, 32'h0), 1'b0, w});
        dir_rows.insert(dir_rows.size(), '{mk_tri(20'd8, 16'd8, 100, 100, 100, 100,
                                    9000, -3, 32'h18000, 32'h18000, 32'h18000), 1'b0, w});
        dir_rows.insert(dir_rows.size(), '{mk_tri(20'd9, 16'd9, 0, 0, 4096, 0, 2048, 3547,
                                    32'hFFFF, 32'h10000, 32'h10001), 1'b0, w});
        dir_rows.insert(dir_rows.size(), '{mk_tri(20'd10, 16'd10, 0, 0, 8388607, 0, 1, 1,
                                    32'h1A0000, 32'h1A0000, 32'h1A0000), 1'b0, w});
        dir_rows.insert(dir_rows.size(), '{mk_tri(20'd11, 16'd11, 0, 0, 65536, 0, 1, 0,
                                    32'd5, 32'd6, 32'd7), 1'b0, w});
        dir_rows.insert(dir_rows.size(), '{mk_tri(20'd12, 16'd12, -5, -5, 10, 10, 25, 25,
                                    32'h14CCC, 32'h15555, 32'h0), 1'b0, w});
        dir_rows.insert(dir_rows.size(), '{mk_tri(20'd13, 16'd13, 0, 0, 3, 0, 0, 4,
                                    32'h400000, 32'h3F0000, 32'h410000), 1'b0, w});
        dir_rows.insert(dir_rows.size(), '{mk_tri(20'd14, 16'd14, 0, 0, 256, 0, 0, 1,
                                    32'h190000, 32'h190000, 32'h190000), 1'b0, w});
        foreach (dir_rows[i])
            send_tri(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);

        // Random phases across period settings, extremes included
        periods = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd25, 7'($urandom_range(2, 63))};
        foreach (periods[p])
        begin
            set_period(periods[p]);
            for (int k = 0; k < 85; k++)
            begin
                quiet = (k >= 60);
                send_tri(rand_tri(), 1'b0, w);
            end
            quiet = 1'b0;
        end
        drain();

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

`default_nettype wire
